/* hdl/assert_macros.svh */
// Assertion helpers; the bodies drop out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check on every rising clk_i edge outside reset.
`define ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check on every rising clk_i edge, reset included.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define ASSERT_RST(label, prop, msg)
`define ASSERT_CLK(label, prop, msg)
`endif

`endif

/* hdl/mftr_pkg.sv */
`default_nettype none

package mftr_pkg;

  typedef enum logic [2:0] {
    CMD_FILL   = 3'd0,
    CMD_CURSOR = 3'd1,
    CMD_PIXEL  = 3'd2,
    CMD_GLYPH  = 3'd3,
    CMD_READ   = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_NO_ROOM = 2'd1,
    STAT_OFF     = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CFG_FONT_WIDTH  = 2'd0,
    CFG_FONT_HEIGHT = 2'd1,
    CFG_INVERT      = 2'd2
  } cfg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_DRAW,
    S_READ,
    S_RDATA,
    S_RESP
  } state_e;

  localparam logic [4:0]  FONT_WIDTH_RST  = 5'd7;
  localparam logic [6:0]  FONT_HEIGHT_RST = 7'd10;
  localparam logic [7:0]  FILL_WHITE      = 8'hFF;
  localparam logic [7:0]  FILL_BLACK      = 8'h00;
  localparam logic [15:0] PIXEL_BITS      = 16'h8000;

endpackage

`default_nettype wire

/* hdl/mftr_ram.sv */
`default_nettype none

module mftr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* hdl/mono_framebuffer_text_renderer_core.sv */
`default_nettype none

// Page-organized monochrome framebuffer with a text cursor. The store holds one
// byte per column per 8-row page (bit y%8 of byte x + (y/8)*SCREEN_WIDTH, 1 is
// white) in a single RAM with one write port and one registered read port.
// Every command transaction returns exactly one result transaction (status,
// read_data). A glyph row is drawn column by column: the read port fetches one
// byte per cycle, the write back of each byte follows in the next cycle, and the
// draw ends after the last write back. Fill writes one byte per cycle over all
// SCREEN_WIDTH * ceil(SCREEN_HEIGHT/8) bytes. After reset the same sweep clears
// the store to black: in_ready_o stays low during the sweep, and configuration
// writes are taken throughout. A finished result sits in an output register, so
// the next command is accepted while it waits. Configuration (font_width,
// font_height, invert) is to be written by the user only while idle; the block
// itself does not enforce it.
module mono_framebuffer_text_renderer_core #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  command_i,
  input  wire logic [7:0]  x_pos_i,
  input  wire logic [7:0]  y_pos_i,
  input  wire logic        color_i,
  input  wire logic [15:0] glyph_bits_i,
  input  wire logic [5:0]  row_index_i,
  input  wire logic        last_row_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic      [1:0]  status_o,
  output logic      [7:0]  read_data_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [6:0]  cfg_data_i
);
  import mftr_pkg::*;

  localparam int PAGES = (SCREEN_HEIGHT + 7) / 8;
  localparam int BYTES = SCREEN_WIDTH * PAGES;
  localparam int AW    = $clog2(BYTES);
  localparam int PW    = AW + 6;
  localparam logic [AW-1:0] LAST_ADDR = AW'(BYTES - 1);

  // Control state
  state_e        state_q, state_d;
  logic [7:0]    cc_q, cc_d;
  logic [7:0]    cr_q, cr_d;
  logic [4:0]    fw_q;
  logic [6:0]    fh_q;
  logic          inv_q;
  logic [AW-1:0] base_q, base_d;
  logic          rd_pend_q, rd_pend_d;
  logic [7:0]    fill_val_q, fill_val_d;
  logic          fill_resp_q, fill_resp_d;
  logic          out_valid_q, out_valid_d;

  // Payload
  logic [4:0]    cnt_q, cnt_d;
  logic [4:0]    lim_q, lim_d;
  logic [15:0]   bits_q, bits_d;
  logic          color_q, color_d;
  logic [2:0]    bitpos_q, bitpos_d;
  logic [AW-1:0] wr_addr_q, wr_addr_d;
  logic          wr_white_q, wr_white_d;
  logic [1:0]    res_status_q, res_status_d;
  logic [7:0]    res_data_q, res_data_d;
  logic [1:0]    out_status_q, out_status_d;
  logic [7:0]    out_data_q, out_data_d;

  // RAM port
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  // Command decode
  logic          in_fire;
  logic          pix_off, rd_off, no_room, row_off;
  logic [8:0]    row_abs;
  logic [AW-1:0] pix_addr, glyph_addr;
  logic          draw_issue, fill_last, out_free;
  logic [7:0]    bit_mask;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign read_data_o = out_data_q;

  always_comb begin
    pix_off    = ({1'b0, x_pos_i} >= 9'(SCREEN_WIDTH)) ||
                 ({1'b0, y_pos_i} >= 9'(SCREEN_HEIGHT));
    rd_off     = ({1'b0, x_pos_i} >= 9'(SCREEN_WIDTH)) ||
                 ({1'b0, y_pos_i[7:3]} >= 6'(PAGES));
    no_room    = (({2'b0, cc_q} + 10'(fw_q)) >= 10'(SCREEN_WIDTH)) ||
                 (({2'b0, cr_q} + 10'(fh_q)) >= 10'(SCREEN_HEIGHT));
    row_abs    = {1'b0, cr_q} + 9'(row_index_i);
    row_off    = row_abs >= 9'(SCREEN_HEIGHT);
    pix_addr   = AW'(PW'(y_pos_i[7:3]) * PW'(SCREEN_WIDTH) + PW'(x_pos_i));
    glyph_addr = AW'(PW'(row_abs[8:3]) * PW'(SCREEN_WIDTH) + PW'(cc_q));
  end

  assign draw_issue = (state_q == S_DRAW) && (cnt_q < lim_q);
  assign fill_last  = (base_q == LAST_ADDR);
  assign out_free   = !out_valid_q || out_ready_i;
  assign bit_mask   = 8'(1) << bitpos_q;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          unique case (command_i)
            CMD_FILL:   state_d = S_FILL;
            CMD_PIXEL:  state_d = pix_off ? S_RESP : S_DRAW;
            CMD_GLYPH:  state_d = (no_room || row_off) ? S_RESP : S_DRAW;
            CMD_READ:   state_d = rd_off ? S_RESP : S_READ;
            default:    state_d = S_RESP;
          endcase
        end
      end
      S_FILL: begin
        if (fill_last) begin
          state_d = fill_resp_q ? S_RESP : S_IDLE;
        end
      end
      S_DRAW: begin
        if (!draw_issue && !rd_pend_q) begin
          state_d = S_RESP;
        end
      end
      S_READ:  state_d = S_RDATA;
      S_RDATA: state_d = S_RESP;
      S_RESP: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and RAM control
  always_comb begin
    cc_d         = cc_q;
    cr_d         = cr_q;
    base_d       = base_q;
    fill_val_d   = fill_val_q;
    fill_resp_d  = fill_resp_q;
    cnt_d        = cnt_q;
    lim_d        = lim_q;
    bits_d       = bits_q;
    color_d      = color_q;
    bitpos_d     = bitpos_q;
    wr_addr_d    = wr_addr_q;
    wr_white_d   = wr_white_q;
    res_status_d = res_status_q;
    res_data_d   = res_data_q;
    out_status_d = out_status_q;
    out_data_d   = out_data_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    rd_pend_d    = draw_issue;
    ram_we       = 1'b0;
    ram_waddr    = base_q;
    ram_wdata    = fill_val_q;
    ram_re       = 1'b0;
    ram_raddr    = base_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          res_status_d = STAT_OK;
          res_data_d   = 8'h00;
          unique case (command_i)
            CMD_FILL: begin
              fill_val_d  = color_i ? FILL_WHITE : FILL_BLACK;
              fill_resp_d = 1'b1;
              base_d      = '0;
            end
            CMD_CURSOR: begin
              cc_d = x_pos_i;
              cr_d = y_pos_i;
            end
            CMD_PIXEL: begin
              if (pix_off) begin
                res_status_d = STAT_OFF;
              end else begin
                // Run a single pixel as a one-column glyph with its bit set.
                base_d   = pix_addr;
                bitpos_d = y_pos_i[2:0];
                cnt_d    = '0;
                lim_d    = 5'd1;
                bits_d   = PIXEL_BITS;
                color_d  = color_i;
              end
            end
            CMD_GLYPH: begin
              if (no_room) begin
                res_status_d = STAT_NO_ROOM;
              end else begin
                if (last_row_i) begin
                  cc_d = 8'({1'b0, cc_q} + 9'(fw_q));
                end
                // A row below the screen draws nothing.
                if (!row_off) begin
                  base_d   = glyph_addr;
                  bitpos_d = row_abs[2:0];
                  cnt_d    = '0;
                  lim_d    = fw_q;
                  bits_d   = glyph_bits_i;
                  color_d  = color_i;
                end
              end
            end
            CMD_READ: begin
              if (rd_off) begin
                res_status_d = STAT_OFF;
              end else begin
                base_d = pix_addr;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = base_q;
        ram_wdata = fill_val_q;
        if (!fill_last) begin
          base_d = base_q + AW'(1);
        end else begin
          fill_resp_d = 1'b0;
        end
      end
      S_DRAW: begin
        // Fetch one column byte per cycle; the shifted-out MSB picks its color.
        if (draw_issue) begin
          ram_re     = 1'b1;
          ram_raddr  = base_q + AW'(cnt_q);
          cnt_d      = cnt_q + 5'd1;
          bits_d     = bits_q << 1;
          wr_addr_d  = base_q + AW'(cnt_q);
          wr_white_d = (bits_q[15] ? color_q : !color_q) ^ inv_q;
        end
      end
      S_READ: begin
        ram_re    = 1'b1;
        ram_raddr = base_q;
      end
      S_RDATA: begin
        res_data_d = ram_rdata;
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_data_d   = res_data_q;
        end
      end
      default: begin
      end
    endcase

    // Write back the byte fetched last cycle with its one bit updated.
    if (rd_pend_q) begin
      ram_we    = 1'b1;
      ram_waddr = wr_addr_q;
      ram_wdata = wr_white_q ? (ram_rdata | bit_mask) : (ram_rdata & ~bit_mask);
    end
  end

  // Control registers; reset starts the clearing sweep.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_FILL;
      cc_q        <= '0;
      cr_q        <= '0;
      base_q      <= '0;
      rd_pend_q   <= 1'b0;
      fill_val_q  <= FILL_BLACK;
      fill_resp_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cc_q        <= cc_d;
      cr_q        <= cr_d;
      base_q      <= base_d;
      rd_pend_q   <= rd_pend_d;
      fill_val_q  <= fill_val_d;
      fill_resp_q <= fill_resp_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q  <= FONT_WIDTH_RST;
      fh_q  <= FONT_HEIGHT_RST;
      inv_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_FONT_WIDTH:  fw_q  <= cfg_data_i[4:0];
        CFG_FONT_HEIGHT: fh_q  <= cfg_data_i;
        CFG_INVERT:      inv_q <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cnt_q        <= cnt_d;
    lim_q        <= lim_d;
    bits_q       <= bits_d;
    color_q      <= color_d;
    bitpos_q     <= bitpos_d;
    wr_addr_q    <= wr_addr_d;
    wr_white_q   <= wr_white_d;
    res_status_q <= res_status_d;
    res_data_q   <= res_data_d;
    out_status_q <= out_status_d;
    out_data_q   <= out_data_d;
  end

  mftr_ram #(
    .WIDTH(8),
    .DEPTH(BYTES)
  ) u_frame_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

`include "assert_macros.svh"

  `ASSERT_RST(a_no_wb_in_fill, (state_q == S_FILL) |-> !rd_pend_q, "write back during fill")
  `ASSERT_RST(a_wb_after_draw, rd_pend_q |-> $past(state_q == S_DRAW), "stray write back")
  `ASSERT_RST(a_cnt_bound, (state_q == S_DRAW) |-> (cnt_q <= lim_q), "column count overrun")
  `ASSERT_RST(a_data_ok, (out_valid_o && (read_data_o != 8'h00)) |-> (status_o == STAT_OK),
              "read data with error status")

endmodule

`default_nettype wire
